// ===== rtl/core/pdt_pkg.sv =====
package pdt_pkg;

    localparam int unsigned TimeWidth = 32;
    localparam int unsigned WaitWidth = 31;
    localparam int unsigned StatusWidth = 2;

    // Status codes returned with every result.
    localparam logic [StatusWidth-1:0] STATUS_OK      = 2'd0;
    localparam logic [StatusWidth-1:0] STATUS_INVALID = 2'd1;
    localparam logic [StatusWidth-1:0] STATUS_REFUSED = 2'd2;

    localparam logic [WaitWidth-1:0] WAIT_MAX = {WaitWidth{1'b1}};

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic                 start;
        logic [TimeWidth-1:0] dividend;
        logic [TimeWidth-1:0] divisor;
    } div_req_t;

    // Answer from the divider.
    typedef struct packed {
        logic                 done;
        logic [TimeWidth-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/pdt_div.sv =====
// Radix-2 restoring divider: one quotient bit per cycle through one subtractor.
module pdt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pdt_pkg::div_req_t req,
    output pdt_pkg::div_rsp_t rsp
);

    localparam int unsigned W = pdt_pkg::TimeWidth;
    localparam int unsigned CW = $clog2(W);
    localparam logic [CW-1:0] LastStep = CW'(W - 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LastStep)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/periodic_deadline_tracker_top.sv =====
// Periodic deadline tracker with overrun counting.
//
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the period in
// milliseconds. cfg_ready is always high, so a write completes at every edge where
// cfg_valid is high. Writes are expected only while the block is idle.
//
// Each input transaction (in_valid, in_stall, now, blocking_allowed) is one
// delay-until request. The block raises in_stall while it works on a request, so it
// holds one request at a time. Each request yields exactly one output transaction
// (out_valid, out_stall, status, wait_time, missed_count).
//
// Without a division an accepted request moves through the PUSH state into the
// output register; an overdue deadline first runs the radix-2 divider in the DIV
// state, one quotient bit per cycle. A new request waits until the state is IDLE.
// When the receiver asserts out_stall the finished result stays in the output
// register; the next request may still be accepted, and its result waits in the
// sequencer until the output register frees up.
//
// Reset clears the period and the deadline cursor (not started) and empties the
// output register.
module periodic_deadline_tracker_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pdt_pkg::TimeWidth-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pdt_pkg::TimeWidth-1:0]      now,
    input  logic                               blocking_allowed,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pdt_pkg::StatusWidth-1:0]    status,
    output logic [pdt_pkg::WaitWidth-1:0]      wait_time,
    output logic [pdt_pkg::TimeWidth-1:0]      missed_count
);

    localparam int unsigned W = pdt_pkg::TimeWidth;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [W-1:0] period_reg;
    logic [W-1:0] cursor_reg, cursor_next;

    // Result held by the sequencer until the output register is free.
    logic [pdt_pkg::StatusWidth-1:0] pend_status_reg, pend_status_next;
    logic [pdt_pkg::WaitWidth-1:0]   pend_wait_reg, pend_wait_next;
    logic [W-1:0]                    pend_missed_reg, pend_missed_next;

    logic                            out_valid_reg, out_valid_next;
    logic [pdt_pkg::StatusWidth-1:0] status_reg, status_next;
    logic [pdt_pkg::WaitWidth-1:0]   wait_reg, wait_next;
    logic [W-1:0]                    missed_reg, missed_next;

    pdt_pkg::div_req_t div_req;
    pdt_pkg::div_rsp_t div_rsp;

    logic         accept;
    logic         out_free;
    logic [W-1:0] ahead_diff;   // cursor - now
    logic [W-1:0] overdue;      // now - cursor

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign ahead_diff = cursor_reg - now;
    assign overdue    = now - cursor_reg;

    pdt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        pend_status_next = pend_status_reg;
        pend_wait_next   = pend_wait_reg;
        pend_missed_next = pend_missed_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        wait_next        = wait_reg;
        missed_next      = missed_reg;
        div_req.start    = 1'b0;
        div_req.dividend = overdue;
        div_req.divisor  = period_reg;

        // The output register empties when its transaction completes.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_status_next = pdt_pkg::STATUS_OK;
                    pend_wait_next   = '0;
                    pend_missed_next = '0;
                    state_next       = ST_PUSH;
                    if (period_reg == '0)
                    begin
                        pend_status_next = pdt_pkg::STATUS_INVALID;
                    end
                    else if (!blocking_allowed)
                    begin
                        pend_status_next = pdt_pkg::STATUS_REFUSED;
                    end
                    else if (cursor_reg == '0)
                    begin
                        // First request arms the cursor and reports no wait.
                        cursor_next = now + period_reg;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + period_reg;
                        if (overdue[W-1])
                        begin
                            // Deadline still ahead; a half-range gap saturates.
                            pend_wait_next = ahead_diff[W-1] ? pdt_pkg::WAIT_MAX
                                                             : ahead_diff[W-2:0];
                        end
                        else if (ahead_diff[W-1])
                        begin
                            // Deadline passed: count missed periods by division.
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                // Overdue is below half range, so quotient + 1 never overflows.
                if (div_rsp.done)
                begin
                    pend_missed_next = div_rsp.quotient + 1'b1;
                    state_next       = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_status_reg;
                    wait_next      = pend_wait_reg;
                    missed_next    = pend_missed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_wait_reg   <= pend_wait_next;
        pend_missed_reg <= pend_missed_next;
        status_reg      <= status_next;
        wait_reg        <= wait_next;
        missed_reg      <= missed_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign wait_time    = wait_reg;
    assign missed_count = missed_reg;

endmodule

// ===== tb/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // One result as the block reports it.
    typedef struct packed {
        logic [pdt_pkg::StatusWidth-1:0] status;
        logic [pdt_pkg::WaitWidth-1:0]   wait_time;
        logic [pdt_pkg::TimeWidth-1:0]   missed_count;
    } deadline_result_t;

    // Rows of the directed script. A period row rewrites the register once the
    // block has gone idle. A request row is checked against the predictor. A known
    // request row carries its expected result typed in by hand.
    typedef enum logic [1:0] {
        ROW_PERIOD,
        ROW_REQUEST,
        ROW_REQUEST_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [pdt_pkg::TimeWidth-1:0] value;
        logic                          may_block;
        deadline_result_t              known;
    } script_row_t;

    localparam int unsigned ScriptRows = 21;
    localparam int unsigned PhaseCount = 12;
    localparam int unsigned HoldOffCycles = 400;
    localparam logic [pdt_pkg::TimeWidth-1:0] TimeMax = {pdt_pkg::TimeWidth{1'b1}};

    // The directed script walks the block through each special case in turn.
    // The deadline cursor is tracked by hand in the comments below.
    script_row_t directed_script [ScriptRows] = '{
        // Period is still zero after reset, so every request is invalid,
        // whether or not blocking is allowed.
        '{ROW_REQUEST_KNOWN, 32'h0000_0000, 1'b1, '{pdt_pkg::STATUS_INVALID, 31'd0, 32'd0}},
        '{ROW_REQUEST_KNOWN, TimeMax,       1'b0, '{pdt_pkg::STATUS_INVALID, 31'd0, 32'd0}},
        '{ROW_PERIOD,        32'd100,       1'b0, '0},
        // A caller that may not block is refused and leaves the cursor alone.
        '{ROW_REQUEST_KNOWN, 32'd1000,      1'b0, '{pdt_pkg::STATUS_REFUSED, 31'd0, 32'd0}},
        // First request arms the cursor at 1100 and reports nothing.
        '{ROW_REQUEST_KNOWN, 32'd1000,      1'b1, '{pdt_pkg::STATUS_OK, 31'd0, 32'd0}},
        // Deadline ahead by 50; the cursor moves to 1200.
        '{ROW_REQUEST,       32'd1050,      1'b1, '0},
        // Deadline exactly now: no wait, no miss; the cursor moves to 1300.
        '{ROW_REQUEST_KNOWN, 32'd1200,      1'b1, '{pdt_pkg::STATUS_OK, 31'd0, 32'd0}},
        // Overdue by 250 with a period of 100 gives three missed periods.
        '{ROW_REQUEST_KNOWN, 32'd1550,      1'b1, '{pdt_pkg::STATUS_OK, 31'd0, 32'd3}},
        '{ROW_REQUEST_KNOWN, 32'd1550,      1'b0, '{pdt_pkg::STATUS_REFUSED, 31'd0, 32'd0}},
        '{ROW_PERIOD,        TimeMax,       1'b0, '0},
        // Cursor 0x578 lies exactly half the range ahead, which still counts as
        // ahead and saturates the wait.
        '{ROW_REQUEST_KNOWN, 32'h8000_0578, 1'b1,
          '{pdt_pkg::STATUS_OK, pdt_pkg::WAIT_MAX, 32'd0}},
        // Cursor is now 0x577; now lies the largest positive distance past it.
        '{ROW_REQUEST,       32'h8000_0576, 1'b1, '0},
        '{ROW_PERIOD,        32'd1,         1'b0, '0},
        // With a period of one, the largest overdue gives the largest miss count.
        '{ROW_REQUEST_KNOWN, 32'h8000_0575, 1'b1,
          '{pdt_pkg::STATUS_OK, 31'd0, 32'h8000_0000}},
        // Cursor 0x577 against the top of the time range: a short wait across the
        // wrap point.
        '{ROW_REQUEST,       TimeMax,       1'b1, '0},
        // This period brings the cursor, 0x578, back to zero on the next advance.
        '{ROW_PERIOD,        32'hFFFF_FA88, 1'b0, '0},
        '{ROW_REQUEST_KNOWN, 32'h0000_0578, 1'b1, '{pdt_pkg::STATUS_OK, 31'd0, 32'd0}},
        // The cursor reads as not started again, and arming it wraps to zero, so
        // it stays not started.
        '{ROW_REQUEST_KNOWN, 32'h0000_0578, 1'b1, '{pdt_pkg::STATUS_OK, 31'd0, 32'd0}},
        // This time it arms at 0xFFFFFB88.
        '{ROW_REQUEST,       32'h0000_0100, 1'b1, '0},
        '{ROW_REQUEST,       32'h7FFF_FFFF, 1'b1, '0},
        '{ROW_REQUEST,       32'hFFFF_FB89, 1'b1, '0}
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pdt_pkg::TimeWidth-1:0]   cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [pdt_pkg::TimeWidth-1:0]   now = '0;
    logic                            blocking_allowed = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [pdt_pkg::StatusWidth-1:0] status;
    logic [pdt_pkg::WaitWidth-1:0]   wait_time;
    logic [pdt_pkg::TimeWidth-1:0]   missed_count;

    periodic_deadline_tracker_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .now              (now),
        .blocking_allowed (blocking_allowed),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .wait_time        (wait_time),
        .missed_count     (missed_count)
    );

    always #5 clk = ~clk;

    // Our own copy of the block's register and deadline cursor. Both change only
    // when a transaction is accepted, so they always match what the block holds
    // once it has worked through every accepted request.
    logic [pdt_pkg::TimeWidth-1:0] tracked_period = '0;
    logic [pdt_pkg::TimeWidth-1:0] tracked_deadline = '0;

    // Results the block still owes us, oldest first.
    deadline_result_t pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;
    bit          hold_request = 1'b0;

    // Computes the result of one request and advances the tracked cursor, exactly
    // as the block must do it.
    function automatic deadline_result_t predict_deadline(
        input logic [pdt_pkg::TimeWidth-1:0] t,
        input logic may_block);
        deadline_result_t result;
        logic [pdt_pkg::TimeWidth-1:0] overdue;
        logic [pdt_pkg::TimeWidth-1:0] ahead;
        logic [pdt_pkg::TimeWidth:0]   periods;
        result = '{pdt_pkg::STATUS_OK, '0, '0};
        if (tracked_period == '0)
        begin
            result.status = pdt_pkg::STATUS_INVALID;
        end
        else if (!may_block)
        begin
            result.status = pdt_pkg::STATUS_REFUSED;
        end
        else if (tracked_deadline == '0)
        begin
            tracked_deadline = t + tracked_period;
        end
        else
        begin
            overdue = t - tracked_deadline;
            // A negative distance, the half-range tie included, means the
            // deadline is still ahead.
            if (overdue[pdt_pkg::TimeWidth-1])
            begin
                ahead = tracked_deadline - t;
                result.wait_time = (ahead > {1'b0, pdt_pkg::WAIT_MAX})
                                   ? pdt_pkg::WAIT_MAX
                                   : ahead[pdt_pkg::WaitWidth-1:0];
            end
            else if (overdue != '0)
            begin
                periods = {1'b0, overdue / tracked_period} + 1'b1;
                result.missed_count = periods[pdt_pkg::TimeWidth]
                                      ? TimeMax
                                      : periods[pdt_pkg::TimeWidth-1:0];
            end
            tracked_deadline = tracked_deadline + tracked_period;
        end
        return result;
    endfunction

    // Picks a request time. Most land around the pending deadline, on either
    // side, so the block spends its time on waits and overruns rather than on
    // arbitrary far-off times.
    function automatic logic [pdt_pkg::TimeWidth-1:0] pick_request_time();
        int unsigned                   choice;
        logic [pdt_pkg::TimeWidth-1:0] span;
        logic [pdt_pkg::TimeWidth-1:0] offset;
        choice = $urandom_range(0, 99);
        span = (tracked_period == '0) ? 32'd1000 : tracked_period;
        offset = $urandom % span;
        if (choice < 10)
        begin
            return $urandom;
        end
        else if (choice < 16)
        begin
            return tracked_deadline;
        end
        else if (choice < 55)
        begin
            return tracked_deadline - offset;
        end
        else if (choice < 82)
        begin
            return tracked_deadline + offset;
        end
        else if (choice < 93)
        begin
            return tracked_deadline + span * $urandom_range(1, 8) + offset;
        end
        return tracked_deadline + ($urandom >> $urandom_range(0, 31));
    endfunction

    // Offers one request. The sender works in bursts: before each burst it drops
    // valid for a random gap. Valid then stays high from one transaction to the
    // next, and the payload only moves on after acceptance.
    task automatic send_request(input logic [pdt_pkg::TimeWidth-1:0] t,
                                input logic may_block,
                                input bit use_known, input deadline_result_t known);
        deadline_result_t predicted;
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        now <= t;
        blocking_allowed <= may_block;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_deadline(t, may_block);
        pending_results.push_back(use_known ? known : predicted);
    endtask

    // Drops valid and waits until every result owed has come back, then a few
    // cycles more so the block is surely idle.
    task automatic settle(input int unsigned tail);
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_period(input logic [pdt_pkg::TimeWidth-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracked_period = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The receiver switches at random among four stall patterns: never stalling,
    // stalling now and then, stalling most of the time, or alternating.
    // On request it holds off for a long stretch so that a finished result sits in
    // the output register, the block takes one more request, and then it has to
    // stall its input while the sender keeps offering.
    always @(negedge clk)
    begin
        static int unsigned pattern_mode = 0;
        static int unsigned pattern_left = 0;
        static int unsigned hold_left = 0;
        static bit toggle = 1'b0;
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HoldOffCycles;
        end
        if (pattern_left == 0)
        begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        toggle = ~toggle;
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (pattern_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= toggle;
            endcase
        end
    end

    // Every accepted result is compared with the oldest one owed, one field at a
    // time, and anything unexpected counts as a failure.
    always @(posedge clk)
    begin
        deadline_result_t owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result with none owed: status %0d wait %0d missed %0d",
                         $time, status, wait_time, missed_count);
                mismatch_count++;
            end
            else
            begin
                owed = pending_results.pop_front();
                if (status !== owed.status)
                begin
                    $display("%0t ns: status expected %0d, got %0d",
                             $time, owed.status, status);
                    mismatch_count++;
                end
                if (wait_time !== owed.wait_time)
                begin
                    $display("%0t ns: wait_time expected %0d, got %0d",
                             $time, owed.wait_time, wait_time);
                    mismatch_count++;
                end
                if (missed_count !== owed.missed_count)
                begin
                    $display("%0t ns: missed_count expected %0d, got %0d",
                             $time, owed.missed_count, missed_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Main stimulus: reset, the directed script, then random phases, each under a
    // fresh period written while the block is idle.
    initial
    begin
        int unsigned                    phase;
        int unsigned                    row;
        int unsigned                    request_total;
        logic [pdt_pkg::TimeWidth-1:0]  next_period;
        logic                           may_block;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < ScriptRows; row++)
        begin
            case (directed_script[row].kind)
                ROW_PERIOD:
                begin
                    settle(4);
                    write_period(directed_script[row].value);
                end
                ROW_REQUEST_KNOWN:
                    send_request(directed_script[row].value, directed_script[row].may_block,
                                 1'b1, directed_script[row].known);
                default:
                    send_request(directed_script[row].value, directed_script[row].may_block,
                                 1'b0, '0);
            endcase
        end

        // Random phases. The fixed periods cover the extremes and the zero period;
        // the rest alternate between short periods and values over the full range.
        for (phase = 0; phase < PhaseCount; phase++)
        begin
            case (phase)
                0: next_period = 32'd1;
                1: next_period = TimeMax;
                2: next_period = '0;
                3: next_period = 32'h8000_0000;
                default: next_period = phase[0] ? $urandom : $urandom_range(2, 3000);
            endcase
            settle(4);
            write_period(next_period);
            if (phase == 5)
                hold_request = 1'b1;
            request_total = (next_period == '0) ? 30 : 160;
            repeat (request_total)
            begin
                may_block = ($urandom_range(0, 99) >= 8);
                send_request(pick_request_time(), may_block, 1'b0, '0);
            end
        end

        // Let the last results drain, then a margin past the slowest latency.
        settle(40);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // A hung handshake ends the run here.
    initial
    begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pdt_pkg.sv
rtl/core/pdt_div.sv
rtl/core/periodic_deadline_tracker_top.sv
tb/testbench.sv
